>>> hw/rtl/rrc_pkg.sv
package rrc_pkg;

  typedef enum logic [1:0] {
    FUNC_REG = 2'd0,
    FUNC_REM = 2'd1,
    FUNC_CHK = 2'd2,
    FUNC_BAD = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_DUP     = 3'd2,
    ST_FULL    = 3'd3,
    ST_NOTFND  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_ZONE   = 3'd0,
    CFG_PAGE   = 3'd1,
    CFG_POISON = 3'd2,
    CFG_USEPAT = 3'd3,
    CFG_USEREG = 3'd4
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int FOLD1      = 8;
  localparam int FOLD2      = 16;
  localparam int FOLD3      = 24;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD1,
    BK_EV1,
    BK_RD2,
    BK_EV2,
    BK_OUT
  } bk_state_t;

endpackage

>>> hw/rtl/rrc_if.sv
interface rrc_in_if #(parameter int ADDR_BITS = 48) (input logic clk);
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] right_addr;
  logic [7:0]           access_size;
  logic [7:0]           first_byte;
  logic [7:0]           last_byte;
  modport source (output valid, func, addr, right_addr, access_size, first_byte,
                  last_byte, input ready);
  modport sink (input valid, func, addr, right_addr, access_size, first_byte,
                last_byte, output ready);
endinterface

interface rrc_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       hit;
  modport source (output valid, status, hit, input ready);
  modport sink (input valid, status, hit, output ready);
endinterface

>>> hw/rtl/rrc_front.sv
// accepts items, computes buckets, the last address and the poison and pattern-only flags, queues them for the back end
module rrc_front #(
  parameter int ADDR_BITS = 48,
  parameter int BKT_W     = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [ADDR_BITS-1:0] right_addr,
  input  logic [7:0]           access_size,
  input  logic [7:0]           first_byte,
  input  logic [7:0]           last_byte,
  input  logic [4:0]           page_shift,
  input  logic [7:0]           poison_byte,
  input  logic                 use_pattern,
  input  logic                 use_registry,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [1:0]           q_func,
  output logic [ADDR_BITS-1:0] q_left,
  output logic [ADDR_BITS-1:0] q_right,
  output logic [ADDR_BITS-1:0] q_last,
  output logic [BKT_W-1:0]     q_lb,
  output logic [BKT_W-1:0]     q_rb,
  output logic                 q_poisoned,
  output logic                 q_pat_only
);
  // two-entry queue
  logic [1:0]           cnt;
  logic                 wp, rp;
  logic [1:0]           e_func  [2];
  logic [ADDR_BITS-1:0] e_left  [2];
  logic [ADDR_BITS-1:0] e_right [2];
  logic [ADDR_BITS-1:0] e_last  [2];
  logic [BKT_W-1:0]     e_lb    [2];
  logic [BKT_W-1:0]     e_rb    [2];
  logic                 e_pois  [2];
  logic                 e_pat   [2];

  logic [ADDR_BITS-1:0] pa, pr, ha, hr, lst;
  logic [7:0]           sz;
  logic                 pois;
  logic                 push, pop;

  always_comb begin
    pa  = addr >> page_shift;
    pr  = right_addr >> page_shift;
    ha  = pa ^ (pa >> rrc_pkg::FOLD1) ^ (pa >> rrc_pkg::FOLD2) ^ (pa >> rrc_pkg::FOLD3);
    hr  = pr ^ (pr >> rrc_pkg::FOLD1) ^ (pr >> rrc_pkg::FOLD2) ^ (pr >> rrc_pkg::FOLD3);
    sz  = (access_size == 8'd0) ? 8'd1 : access_size;
    lst = addr + ADDR_BITS'(sz - 8'd1);
    pois = (first_byte == poison_byte) || (sz > 8'd1 && last_byte == poison_byte);
  end

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      e_func[wp]  <= func;
      e_left[wp]  <= addr;
      e_right[wp] <= right_addr;
      e_last[wp]  <= lst;
      e_lb[wp]    <= ha[BKT_W-1:0];
      e_rb[wp]    <= hr[BKT_W-1:0];
      e_pois[wp]  <= pois;
      e_pat[wp]   <= (use_registry == 1'b0) || (use_pattern && !pois);
    end
  end

  assign q_func     = e_func[rp];
  assign q_left     = e_left[rp];
  assign q_right    = e_right[rp];
  assign q_last     = e_last[rp];
  assign q_lb       = e_lb[rp];
  assign q_rb       = e_rb[rp];
  assign q_poisoned = e_pois[rp];
  assign q_pat_only = e_pat[rp];
endmodule

>>> hw/rtl/rrc_back.sv
// bucket table: one row per bucket, read one or two rows, evaluate, write back
module rrc_back #(
  parameter int BUCKETS   = 256,
  parameter int WAYS      = 8,
  parameter int ADDR_BITS = 48,
  parameter int BKT_W     = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [1:0]           q_func,
  input  logic [ADDR_BITS-1:0] q_left,
  input  logic [ADDR_BITS-1:0] q_right,
  input  logic [ADDR_BITS-1:0] q_last,
  input  logic [BKT_W-1:0]     q_lb,
  input  logic [BKT_W-1:0]     q_rb,
  input  logic                 q_poisoned,
  input  logic                 q_pat_only,
  input  logic [3:0]           zone_size_log2,
  input  logic [4:0]           page_shift,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic                 hit
);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef logic [WAYS-1:0][ADDR_BITS-1:0] row_addr_t;

  row_addr_t            mem_l [BUCKETS];
  row_addr_t            mem_r [BUCKETS];
  logic [WAYS-1:0]      vld [BUCKETS];
  row_addr_t            rd_l, rd_r;
  logic [WAYS-1:0]      rd_v;
  logic [BKT_W-1:0]     clr_idx;
  logic                 clr_busy;

  rrc_pkg::bk_state_t   state, state_next;
  logic [1:0]           func;
  logic [ADDR_BITS-1:0] l, r, lst;
  logic [BKT_W-1:0]     lb, rb;
  logic [2:0]           status_next;
  logic                 hit_next;
  logic [WAYS-1:0]      v1;
  logic [WAYS-1:0]      v1_next;
  logic [ADDR_BITS-1:0] sl, sr, sl_next, sr_next;
  logic [BKT_W-1:0]     rb2, rb2_next;
  logic [BKT_W-1:0]     sr_bkt;

  logic [BKT_W-1:0]     rd_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [BKT_W-1:0]     wr_addr;
  logic [WAYS-1:0]      wr_v;
  logic                 wr_data;
  logic [WAY_W-1:0]     wr_way;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [ADDR_BITS-1:0] a,
                                                 input logic [4:0] sh);
    logic [ADDR_BITS-1:0] p, h;
    p = a >> sh;
    h = p ^ (p >> rrc_pkg::FOLD1) ^ (p >> rrc_pkg::FOLD2) ^ (p >> rrc_pkg::FOLD3);
    return h[BKT_W-1:0];
  endfunction

  assign sr_bkt = bucket_of(sr, page_shift);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_l <= mem_l[rd_addr];
      rd_r <= mem_r[rd_addr];
      rd_v <= vld[rd_addr];
    end
    if (wr_en) begin
      vld[wr_addr] <= wr_v;
      if (wr_data) begin
        mem_l[wr_addr][wr_way] <= l;
        mem_r[wr_addr][wr_way] <= r;
      end
    end
    if (clr_busy) vld[clr_idx] <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + BKT_W'(1);
      if (clr_idx == BKT_W'(BUCKETS - 1)) clr_busy <= 1'b0;
    end
  end

  // per-way compares on the row just read
  logic [ADDR_BITS:0]   len;
  logic [WAYS-1:0]      m_dup, m_rem, m_pair, m_hit;
  logic [WAY_W-1:0]     free_w, rem_w, pair_w;
  logic                 has_free, has_rem, has_pair;

  function automatic logic in_zone(input logic [ADDR_BITS-1:0] a,
                                   input logic [ADDR_BITS-1:0] s,
                                   input logic [ADDR_BITS:0] ln);
    logic [ADDR_BITS-1:0] d;
    d = a - s;
    return (a >= s) && ({1'b0, d} < ln);
  endfunction

  always_comb begin
    len = (ADDR_BITS+1)'(1) << zone_size_log2;
    for (int w = 0; w < WAYS; w++) begin
      m_dup[w]  = rd_v[w] && (rd_l[w] == l || rd_r[w] == r);
      m_rem[w]  = rd_v[w] && (rd_l[w] == l || (r != '0 && rd_r[w] == r));
      m_pair[w] = rd_v[w] && rd_l[w] == sl && rd_r[w] == sr;
      m_hit[w]  = rd_v[w] && (in_zone(l, rd_l[w], len) || in_zone(l, rd_r[w], len) ||
                  in_zone(lst, rd_l[w], len) || in_zone(lst, rd_r[w], len));
    end
    free_w = '0; has_free = 1'b0;
    rem_w = '0; has_rem = 1'b0;
    pair_w = '0; has_pair = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!rd_v[w]) begin free_w = WAY_W'(w); has_free = 1'b1; end
      if (m_rem[w]) begin rem_w = WAY_W'(w); has_rem = 1'b1; end
      if (m_pair[w]) begin pair_w = WAY_W'(w); has_pair = 1'b1; end
    end
  end

  logic free1, free1_next;
  logic [WAY_W-1:0] fw1, fw1_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrc_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rrc_pkg::BK_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      func <= q_func; l <= q_left; r <= q_right; lst <= q_last;
      lb <= q_lb; rb <= q_rb;
    end
    if (state == rrc_pkg::BK_OUT) begin
      status <= status_next;
      hit    <= hit_next;
    end
    v1   <= v1_next;
    sl   <= sl_next;
    sr   <= sr_next;
    rb2  <= rb2_next;
    free1 <= free1_next;
    fw1  <= fw1_next;
  end

  logic [2:0] st_r, st_r_next;
  logic       ht_r, ht_r_next;
  always_ff @(posedge clk) begin
    st_r <= st_r_next;
    ht_r <= ht_r_next;
  end
  assign status_next = st_r;
  assign hit_next    = ht_r;

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = lb;
    wr_en      = 1'b0;
    wr_addr    = lb;
    wr_v       = rd_v;
    wr_data    = 1'b0;
    wr_way     = free_w;
    st_r_next  = st_r;
    ht_r_next  = ht_r;
    v1_next    = v1;
    sl_next    = sl;
    sr_next    = sr;
    rb2_next   = rb2;
    free1_next = free1;
    fw1_next   = fw1;
    unique case (state)
      rrc_pkg::BK_IDLE: begin
        q_ready = !clr_busy && !(out_valid && !out_ready);
        if (q_valid && q_ready) begin
          rd_en     = 1'b1;
          rd_addr   = q_lb;
          st_r_next = rrc_pkg::ST_OK;
          ht_r_next = 1'b0;
          state_next = rrc_pkg::BK_EV1;
          unique case (rrc_pkg::func_t'(q_func))
            rrc_pkg::FUNC_REG:
              if (q_left == '0 || q_right == '0) begin
                st_r_next = rrc_pkg::ST_INVALID; state_next = rrc_pkg::BK_OUT;
              end
            rrc_pkg::FUNC_REM:
              if (q_left == '0) begin
                st_r_next = rrc_pkg::ST_INVALID; state_next = rrc_pkg::BK_OUT;
              end
            rrc_pkg::FUNC_CHK:
              if (q_left == '0) begin
                st_r_next = rrc_pkg::ST_INVALID; state_next = rrc_pkg::BK_OUT;
              end else if (q_pat_only) begin
                // pattern decides alone, or an unpoisoned access is let through
                ht_r_next = q_poisoned;
                state_next = rrc_pkg::BK_OUT;
              end
            default: begin
              st_r_next = rrc_pkg::ST_INVALID; state_next = rrc_pkg::BK_OUT;
            end
          endcase
        end
      end
      rrc_pkg::BK_EV1: begin
        v1_next    = rd_v;
        free1_next = has_free;
        fw1_next   = free_w;
        state_next = rrc_pkg::BK_OUT;
        unique case (rrc_pkg::func_t'(func))
          rrc_pkg::FUNC_REG: begin
            if (|m_dup) st_r_next = rrc_pkg::ST_DUP;
            else if (rb != lb) begin
              rd_en = 1'b1; rd_addr = rb; rb2_next = rb; state_next = rrc_pkg::BK_EV2;
            end else if (!has_free) st_r_next = rrc_pkg::ST_FULL;
            else begin
              wr_en = 1'b1; wr_data = 1'b1; wr_way = free_w;
              wr_v = rd_v; wr_v[free_w] = 1'b1;
            end
          end
          rrc_pkg::FUNC_REM: begin
            if (!has_rem) st_r_next = rrc_pkg::ST_NOTFND;
            else begin
              wr_en = 1'b1;
              wr_v = rd_v; wr_v[rem_w] = 1'b0;
              sl_next = rd_l[rem_w];
              sr_next = rd_r[rem_w];
              state_next = rrc_pkg::BK_RD2;
            end
          end
          default: ht_r_next = |m_hit;
        endcase
      end
      rrc_pkg::BK_RD2: begin
        // stored right address picks the twin bucket
        rd_en = 1'b1; rd_addr = sr_bkt; rb2_next = sr_bkt; state_next = rrc_pkg::BK_EV2;
      end
      rrc_pkg::BK_EV2: begin
        state_next = rrc_pkg::BK_OUT;
        wr_addr = rb2;
        if (func == rrc_pkg::FUNC_REG) begin
          if (|m_dup) st_r_next = rrc_pkg::ST_DUP;
          else if (!free1 || !has_free) st_r_next = rrc_pkg::ST_FULL;
          else begin
            wr_en = 1'b1; wr_data = 1'b1; wr_way = free_w;
            wr_v = rd_v; wr_v[free_w] = 1'b1;
            state_next = rrc_pkg::BK_RD1;
          end
        end else if (rb2 != lb && has_pair) begin
          wr_en = 1'b1;
          wr_v = rd_v; wr_v[pair_w] = 1'b0;
        end
      end
      rrc_pkg::BK_RD1: begin
        // write the left copy into the first bucket's free way
        wr_en = 1'b1; wr_addr = lb; wr_data = 1'b1; wr_way = fw1;
        wr_v = v1; wr_v[fw1] = 1'b1;
        state_next = rrc_pkg::BK_OUT;
      end
      rrc_pkg::BK_OUT: state_next = rrc_pkg::BK_IDLE;
      default: state_next = rrc_pkg::BK_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/redzone_registry_checker_core.sv
// channel | dir | fields
// in      | in  | func, addr, right_addr, access_size, first_byte, last_byte
// out     | out | status, hit
// cfg     | in  | cfg_we, cfg_idx, cfg_data
// in the back end an item needs one or two bucket-row reads
// of the single-port table and their write-backs.
// after reset a clearing pass over all BUCKETS rows runs before the first item.
// a two-entry queue and an output register let either side stall alone.
module redzone_registry_checker_core #(
  parameter int BUCKETS   = 256,
  parameter int WAYS      = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  rrc_in_if.sink                          in_ch,
  rrc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rrc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  logic [3:0] zone_size_log2;
  logic [4:0] page_shift;
  logic [7:0] poison_byte;
  logic       use_pattern, use_registry;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_size_log2 <= 4'd7;
      page_shift     <= 5'd12;
      poison_byte    <= 8'hFF;
      use_pattern    <= 1'b1;
      use_registry   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rrc_pkg::CFG_ZONE:   zone_size_log2 <= cfg_data[3:0];
        rrc_pkg::CFG_PAGE:   page_shift     <= cfg_data[4:0];
        rrc_pkg::CFG_POISON: poison_byte    <= cfg_data;
        rrc_pkg::CFG_USEPAT: use_pattern    <= cfg_data[0];
        rrc_pkg::CFG_USEREG: use_registry   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic                 q_valid, q_ready, q_pois, q_pat;
  logic [1:0]           q_func;
  logic [ADDR_BITS-1:0] q_left, q_right, q_last;
  logic [BKT_W-1:0]     q_lb, q_rb;

  rrc_front #(.ADDR_BITS(ADDR_BITS), .BKT_W(BKT_W)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .func(in_ch.func),
    .addr(in_ch.addr), .right_addr(in_ch.right_addr),
    .access_size(in_ch.access_size), .first_byte(in_ch.first_byte),
    .last_byte(in_ch.last_byte),
    .page_shift, .poison_byte, .use_pattern, .use_registry,
    .q_valid, .q_ready, .q_func, .q_left, .q_right, .q_last, .q_lb, .q_rb,
    .q_poisoned(q_pois), .q_pat_only(q_pat)
  );

  rrc_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS), .BKT_W(BKT_W))
  u_back (
    .clk, .rst, .q_valid, .q_ready, .q_func, .q_left, .q_right, .q_last,
    .q_lb, .q_rb, .q_poisoned(q_pois), .q_pat_only(q_pat), .zone_size_log2,
    .page_shift,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.status), .hit(out_ch.hit)
  );
endmodule
